// ===== rtl/rbst_pkg.sv =====
// Shared constants and types for the ray versus box slab test.
package rbst_pkg;

  localparam int COORD_W_DEF = 32;
  localparam int FRAC_DEF    = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int PAD_EXT     = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_PAD_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_HALF      = 8'd1;

  localparam logic [CFG_W-1:0] PAD_THRESHOLD_RST = 16'd7;
  localparam logic [CFG_W-1:0] PAD_HALF_RST      = 16'd3;

  // per-axis flags carried alongside the divider pipeline
  typedef struct packed {
    logic miss;
    logic swap;
  } ax_flag_t;

endpackage

// ===== rtl/rbst_div.sv =====
// Pipelined saturating fixed-point divider, one quotient bit per stage.
module rbst_div import rbst_pkg::*; #(
  parameter int W = COORD_W_DEF,
  parameter int F = FRAC_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] corner,
  input  logic signed [W-1:0] org,
  input  logic signed [W-1:0] d,
  output logic signed [W-1:0] t
);

  localparam int NW = 2 * W + F;
  localparam int S  = W - 1;

  logic [W-1:0] r_r   [0:S];
  logic [S-1:0] n_r   [0:S];
  logic [S-1:0] q_r   [0:S];
  logic [W-1:0] dm_r  [0:S];
  logic         neg_r [0:S];
  logic         ovf_r [0:S];
  logic signed [W-1:0] t_r;

  logic signed [W:0] diff, dext;
  logic [W:0]        nabs, dabs;
  logic [W-1:0]      nm, dm;
  logic [NW-1:0]     lhs, rhs;

  // form magnitudes, overflow flag and first partial remainder
  always_comb begin
    diff = {corner[W-1], corner} - {org[W-1], org};
    dext = {d[W-1], d};
    nabs = diff[W] ? 0 - diff : diff;
    dabs = d[W-1] ? 0 - dext : dext;
    nm   = nabs[W-1:0];
    dm   = dabs[W-1:0];
    lhs  = NW'(nm) << F;
    rhs  = NW'(dm) << (W - 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= lhs[2*W-2:W-1];
      n_r[0]   <= lhs[W-2:0];
      q_r[0]   <= '0;
      dm_r[0]  <= dm;
      neg_r[0] <= diff[W] ^ d[W-1];
      ovf_r[0] <= lhs >= rhs;
    end
  end

  // restoring division steps
  for (genvar k = 0; k < S; k++) begin : g_step
    logic [W:0] rc, rs;
    logic       ge;
    always_comb begin
      rc = {r_r[k], n_r[k][S-1]};
      ge = rc >= {1'b0, dm_r[k]};
      rs = ge ? rc - {1'b0, dm_r[k]} : rc;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1]   <= rs[W-1:0];
        n_r[k+1]   <= {n_r[k][S-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][S-2:0], ge};
        dm_r[k+1]  <= dm_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  // apply sign and saturate
  logic signed [W-1:0] qx, t_nxt;
  always_comb begin
    qx = {1'b0, q_r[S]};
    if (neg_r[S]) begin
      t_nxt = ovf_r[S] ? {1'b1, {(W-1){1'b0}}} : 0 - qx;
    end else begin
      t_nxt = ovf_r[S] ? {1'b0, {(W-1){1'b1}}} : qx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_nxt;
    end
  end

  assign t = t_r;

endmodule

// ===== rtl/rbst_lane.sv =====
// One axis lane: thin-box padding, two distance dividers, entry/exit ordering.
module rbst_lane import rbst_pkg::*; #(
  parameter int W = COORD_W_DEF,
  parameter int F = FRAC_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [CFG_W-1:0]    pad_threshold,
  input  logic [CFG_W-1:0]    pad_half,
  input  logic signed [W-1:0] org,
  input  logic signed [W-1:0] d,
  input  logic signed [W-1:0] lo,
  input  logic signed [W-1:0] hi,
  output logic signed [W-1:0] t_in,
  output logic signed [W-1:0] t_out,
  output logic                miss
);

  localparam int XW  = W + PAD_EXT;
  localparam int LAT = W + 1;

  logic signed [XW-1:0] lo_x, hi_x, thr_x, p_x, ext, lo_s, hi_s, cmin_x, cmax_x;
  logic                 thin;
  logic signed [W-1:0]  lo_nxt, hi_nxt;
  logic signed [W-1:0]  lo_r, hi_r, org_r, d_r;

  // widen thin axes, saturating at the coordinate range
  always_comb begin
    lo_x   = {{PAD_EXT{lo[W-1]}}, lo};
    hi_x   = {{PAD_EXT{hi[W-1]}}, hi};
    thr_x  = XW'(pad_threshold);
    p_x    = XW'(pad_half);
    cmin_x = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
    cmax_x = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    ext    = hi_x - lo_x;
    thin   = ext < thr_x;
    lo_s   = lo_x - p_x;
    hi_s   = hi_x + p_x;
    lo_nxt = lo;
    hi_nxt = hi;
    if (thin) begin
      lo_nxt = (lo_s < cmin_x) ? cmin_x[W-1:0] : lo_s[W-1:0];
      hi_nxt = (hi_s > cmax_x) ? cmax_x[W-1:0] : hi_s[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      org_r <= org;
      d_r   <= d;
    end
  end

  logic signed [W-1:0] t_lo, t_hi;

  rbst_div #(.W(W), .F(F)) u_div_lo (
    .clk(clk), .en(en), .corner(lo_r), .org(org_r), .d(d_r), .t(t_lo)
  );

  rbst_div #(.W(W), .F(F)) u_div_hi (
    .clk(clk), .en(en), .corner(hi_r), .org(org_r), .d(d_r), .t(t_hi)
  );

  // hold zero-direction verdict and swap flag beside the dividers
  ax_flag_t flag_r [0:LAT-1];
  ax_flag_t flag_nxt;

  always_comb begin
    flag_nxt.swap = d_r[W-1];
    flag_nxt.miss = (d_r == '0) && ((org_r < lo_r) || (org_r > hi_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag_r[0] <= flag_nxt;
      for (int i = 1; i < LAT; i++) begin
        flag_r[i] <= flag_r[i-1];
      end
    end
  end

  // a zero direction leaves near and far alone
  logic zero_d_r [0:LAT-1];
  always_ff @(posedge clk) begin
    if (en) begin
      zero_d_r[0] <= (d_r == '0);
      for (int i = 1; i < LAT; i++) begin
        zero_d_r[i] <= zero_d_r[i-1];
      end
    end
  end

  always_comb begin
    if (zero_d_r[LAT-1]) begin
      t_in  = '0;
      t_out = {1'b0, {(W-1){1'b1}}};
    end else if (flag_r[LAT-1].swap) begin
      t_in  = t_hi;
      t_out = t_lo;
    end else begin
      t_in  = t_lo;
      t_out = t_hi;
    end
  end

  assign miss = flag_r[LAT-1].miss;

endmodule

// ===== rtl/rbst_merge.sv =====
// Merge stage: combine lane distances into near/far and register the verdict.
module rbst_merge import rbst_pkg::*; #(
  parameter int W = COORD_W_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] t_in  [0:2],
  input  logic signed [W-1:0] t_out [0:2],
  input  logic [2:0]          miss,
  output logic                hit
);

  logic signed [W-1:0] near_v, far_v;
  logic                hit_r;

  // running max of entry and min of exit
  always_comb begin
    near_v = '0;
    far_v  = {1'b0, {(W-1){1'b1}}};
    for (int a = 0; a < 3; a++) begin
      if (t_in[a] > near_v) near_v = t_in[a];
      if (t_out[a] < far_v) far_v = t_out[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= (miss == '0) && (near_v < far_v);
    end
  end

  assign hit = hit_r;

endmodule

// ===== rtl/ray_box_slab_test.sv =====
// Top level of the ray versus axis-aligned box slab test.
// Requests pass through the lane input registers, the divider pipeline, which
// resolves one quotient bit per stage, and the registered merge verdict.
// Throughput: one request per cycle; the whole pipeline holds while a
// finished result waits on out_ready.
// Reset clears all valid flags and loads pad_threshold = 7, pad_half = 3.
module ray_box_slab_test import rbst_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF,
  parameter int FRAC_BITS   = FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_origin_z,
  input  logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_dir_z,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_z,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int W   = COORD_WIDTH;
  localparam int LAT = W + 3;

  logic [CFG_W-1:0] thr_r, half_r;
  logic [LAT-1:0]   vld_r;
  logic             en;

  // advance the pipeline unless a result is stuck at the output
  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= PAD_THRESHOLD_RST;
      half_r <= PAD_HALF_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PAD_THRESHOLD: thr_r  <= cfg_data;
        CFG_PAD_HALF:      half_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  logic signed [W-1:0] org  [0:2];
  logic signed [W-1:0] dir  [0:2];
  logic signed [W-1:0] bmin [0:2];
  logic signed [W-1:0] bmax [0:2];
  logic signed [W-1:0] t_in [0:2];
  logic signed [W-1:0] t_out[0:2];
  logic [2:0]          miss;

  assign org  = '{in_origin_x, in_origin_y, in_origin_z};
  assign dir  = '{in_dir_x, in_dir_y, in_dir_z};
  assign bmin = '{in_box_min_x, in_box_min_y, in_box_min_z};
  assign bmax = '{in_box_max_x, in_box_max_y, in_box_max_z};

  for (genvar a = 0; a < 3; a++) begin : g_lane
    rbst_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk(clk), .en(en), .pad_threshold(thr_r), .pad_half(half_r),
      .org(org[a]), .d(dir[a]), .lo(bmin[a]), .hi(bmax[a]),
      .t_in(t_in[a]), .t_out(t_out[a]), .miss(miss[a])
    );
  end

  rbst_merge #(.W(W)) u_merge (
    .clk(clk), .en(en), .t_in(t_in), .t_out(t_out), .miss(miss), .hit(out_hit)
  );

  assign out_valid = vld_r[LAT-1];

  // an accepted request enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted request did not enter pipeline");

  // stalled pipeline keeps its occupancy
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  // threshold write lands in the register
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_index == CFG_PAD_THRESHOLD) |=> thr_r == $past(cfg_data))
    else $error("pad threshold write lost");

endmodule
